FILE: sv/sdsr_pkg.sv
// Shared types and constants for the short-name directory search block.
`default_nettype none
package sdsr_pkg;

    // Name geometry
    localparam int unsigned NAME_LEN = 11;
    localparam int unsigned POS_W    = 4;
    localparam logic [3:0]  EXT_POS  = 4'd8;
    localparam logic [3:0]  LAST_POS = 4'd11;

    // Characters and masks
    localparam logic [7:0] SPACE     = 8'h20;
    localparam logic [7:0] DOT       = 8'h2E;
    localparam logic [7:0] SKIP_MASK = 8'h18;

    // Register reset
    localparam logic [15:0] MAX_ENTRIES_RST = 16'd224;

    // Request codes
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_CHAR  = 2'd1;
    localparam logic [1:0] REQ_ENTRY = 2'd2;

    // Result codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_TOOLONG  = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;

    // Search state and entry flags handed to the merge stage
    typedef struct packed {
        logic done;
        logic too_long;
        logic limit_hit;
        logic head_zero;
        logic skip;
    } t_merge_ctl;

endpackage
`default_nettype wire

FILE: sv/sdsr_lane.sv
// One byte lane: holds one pattern byte and compares it with one entry name byte.
`default_nettype none
module sdsr_lane (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_clr,
    input  wire logic       i_wr,
    input  wire logic [7:0] i_wr_data,
    input  wire logic [7:0] i_entry_byte,
    output logic            o_eq
);

    logic [7:0] r_pat;

    // Pattern byte: spaces after reset or begin, written by a stored character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_pat <= sdsr_pkg::SPACE;
        end else if (i_wr) begin
            r_pat <= i_wr_data;
        end
    end

    assign o_eq = (i_entry_byte == r_pat);

endmodule
`default_nettype wire

FILE: sv/sdsr_merge.sv
// Merge stage: folds the lane compares and entry flags into one status code.
`default_nettype none
module sdsr_merge (
    input  wire logic [sdsr_pkg::NAME_LEN-1:0] i_lane_eq,
    input  wire sdsr_pkg::t_merge_ctl          i_ctl,
    output logic [2:0]                         o_status
);

    logic w_all_eq;

    assign w_all_eq = &i_lane_eq;

    // Priority: finished, too long, end of directory, match, keep going
    always_comb begin
        if (i_ctl.done) begin
            o_status = sdsr_pkg::ST_FINISHED;
        end else if (i_ctl.too_long) begin
            o_status = sdsr_pkg::ST_TOOLONG;
        end else if (i_ctl.limit_hit || i_ctl.head_zero) begin
            o_status = sdsr_pkg::ST_NOTFOUND;
        end else if (!i_ctl.skip && w_all_eq) begin
            o_status = sdsr_pkg::ST_FOUND;
        end else begin
            o_status = sdsr_pkg::ST_NONE;
        end
    end

endmodule
`default_nettype wire

FILE: sv/short_name_directory_search.sv
// Top level: 8.3 short-name directory search with eleven compare lanes.
// A result appears on o_valid in the cycle after its entry beat is accepted.
// Throughput: one beat per cycle while o_stall is low; all eleven name bytes are compared in parallel.
// Begin and character beats give no result.
// Reset (i_rst_n low, synchronous): pattern to spaces, search state cleared,
// max_entries to 224, output register empty.
`default_nettype none
module short_name_directory_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beats
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_name_char,
    input  wire logic [63:0] i_entry_name_head,
    input  wire logic [23:0] i_entry_name_tail,
    input  wire logic [7:0]  i_entry_type,
    // result beats
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_entry_index,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_max_entries
);

    localparam int unsigned NL = sdsr_pkg::NAME_LEN;

    logic [15:0]                  r_max_entries;
    logic [sdsr_pkg::POS_W-1:0]   r_name_pos;
    logic                         r_too_long;
    logic [15:0]                  r_entry_count;
    logic                         r_done;
    logic                         r_out_valid;
    logic [2:0]                   r_out_status;
    logic [15:0]                  r_out_index;

    logic                         w_acc;
    logic                         w_begin;
    logic                         w_char;
    logic                         w_entry;
    logic                         w_char_live;
    logic                         w_char_over;
    logic                         w_char_dot;
    logic                         w_char_store;
    logic [7:0]                   w_char_up;
    logic [NL-1:0]                w_lane_wr;
    logic [NL-1:0]                w_lane_eq;
    logic [7:0]                   w_entry_byte [NL];
    sdsr_pkg::t_merge_ctl         w_ctl;
    logic [2:0]                   w_status;

    // Handshakes
    assign o_stall     = r_out_valid && i_stall;
    assign w_acc       = i_valid && !o_stall;
    assign w_begin     = w_acc && (i_req_type == sdsr_pkg::REQ_BEGIN);
    assign w_char      = w_acc && (i_req_type == sdsr_pkg::REQ_CHAR);
    assign w_entry     = w_acc && (i_req_type == sdsr_pkg::REQ_ENTRY);
    assign o_cfg_ready = 1'b1;

    // Character decode: ignore (NUL or too long), overflow, extension dot, or store upper-cased
    assign w_char_live  = w_char && (i_name_char != 8'd0) && !r_too_long;
    assign w_char_over  = w_char_live && (r_name_pos >= sdsr_pkg::LAST_POS);
    assign w_char_dot   = w_char_live && !w_char_over && (i_name_char == sdsr_pkg::DOT)
                          && (r_name_pos <= sdsr_pkg::EXT_POS);
    assign w_char_store = w_char_live && !w_char_over && !w_char_dot;
    assign w_char_up    = (i_name_char inside {[8'h61:8'h7A]})
                          ? (i_name_char - sdsr_pkg::SPACE) : i_name_char;

    // Byte lanes
    for (genvar k = 0; k < NL; k++) begin : g_lane
        if (k < 8) begin : g_head
            assign w_entry_byte[k] = i_entry_name_head[8*k +: 8];
        end else begin : g_tail
            assign w_entry_byte[k] = i_entry_name_tail[8*(k-8) +: 8];
        end
        assign w_lane_wr[k] = w_char_store && (r_name_pos == sdsr_pkg::POS_W'(k));

        sdsr_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_clr        (w_begin),
            .i_wr         (w_lane_wr[k]),
            .i_wr_data    (w_char_up),
            .i_entry_byte (w_entry_byte[k]),
            .o_eq         (w_lane_eq[k])
        );
    end

    // Merge of lane results with search state
    assign w_ctl.done      = r_done;
    assign w_ctl.too_long  = r_too_long;
    assign w_ctl.limit_hit = (r_entry_count >= r_max_entries);
    assign w_ctl.head_zero = (i_entry_name_head[7:0] == 8'd0);
    assign w_ctl.skip      = ((i_entry_type & sdsr_pkg::SKIP_MASK) != 8'd0);

    sdsr_merge u_merge (
        .i_lane_eq (w_lane_eq),
        .i_ctl     (w_ctl),
        .o_status  (w_status)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= sdsr_pkg::MAX_ENTRIES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_entries <= i_cfg_max_entries;
        end
    end

    // Search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_begin) begin
            r_name_pos    <= '0;
            r_too_long    <= 1'b0;
            r_entry_count <= '0;
            r_done        <= 1'b0;
        end else begin
            if (w_char_over) begin
                r_too_long <= 1'b1;
            end
            if (w_char_dot) begin
                r_name_pos <= sdsr_pkg::EXT_POS;
            end else if (w_char_store) begin
                r_name_pos <= r_name_pos + 1'b1;
            end
            if (w_entry) begin
                if (w_status == sdsr_pkg::ST_NONE) begin
                    r_entry_count <= r_entry_count + 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_entry) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_entry) begin
            r_out_status <= w_status;
            r_out_index  <= r_entry_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_index;

`ifndef SYNTH
    // Write position never passes the end of the name
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_pos <= sdsr_pkg::LAST_POS)
        else $error("name position out of range");

    // Too long is only flagged with a full pattern
    a_too_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> (r_name_pos == sdsr_pkg::LAST_POS))
        else $error("too long without full pattern");

    // Every accepted entry beat shows up as a result next cycle
    a_entry_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry |=> o_valid)
        else $error("entry beat lost");

    // A final status ends the search
    a_final_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_entry && (w_status != sdsr_pkg::ST_NONE)) |=> r_done)
        else $error("search not finished after final status");

    // Once finished, the entry count does not move until a begin
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !w_begin) |=> $stable(r_entry_count))
        else $error("entry count moved after finish");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the short-name directory search block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Reserved request code, ignored by the block
    localparam logic [1:0] REQ_RSVD = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  ch;
        logic [63:0] head;
        logic [23:0] tail;
        logic [7:0]  etype;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] index;
    } t_res;

    // Directed row: request plus an optional hand-written result
    typedef struct packed {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = sdsr_pkg::REQ_BEGIN;
    logic [7:0]  i_name_char = '0;
    logic [63:0] i_entry_name_head = '0;
    logic [23:0] i_entry_name_tail = '0;
    logic [7:0]  i_entry_type = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_entry_index;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_max_entries = '0;

    short_name_directory_search dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_name_char       (i_name_char),
        .i_entry_name_head (i_entry_name_head),
        .i_entry_name_tail (i_entry_name_tail),
        .i_entry_type      (i_entry_type),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_entry_index     (o_entry_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_max_entries (i_cfg_max_entries)
    );

    // Search state mirror
    logic [7:0]  name_pat [sdsr_pkg::NAME_LEN];
    logic [3:0]  name_pos;
    bit          name_long;
    logic [15:0] entry_cnt;
    bit          search_over;
    logic [15:0] entry_limit;

    t_res expected_results [$];
    t_res oldest_result;
    t_row dir_rows [$];
    int   mismatch_count = 0;
    int   idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function void clear_search_state();
        for (int k = 0; k < sdsr_pkg::NAME_LEN; k++) name_pat[k] = sdsr_pkg::SPACE;
        name_pos    = '0;
        name_long   = 1'b0;
        entry_cnt   = '0;
        search_over = 1'b0;
    endfunction

    // Predict the outcome of one accepted beat and advance the mirror
    task search_predict(input t_req it, output bit has, output t_res res);
        logic [7:0] c;
        bit         hit;
        has = 1'b0;
        res = '{sdsr_pkg::ST_NONE, 16'd0};
        case (it.req)
            sdsr_pkg::REQ_BEGIN: clear_search_state();
            sdsr_pkg::REQ_CHAR: begin
                c = it.ch;
                if (c != 8'h00 && !name_long) begin
                    if (name_pos >= sdsr_pkg::LAST_POS) begin
                        name_long = 1'b1;
                    end else if (c == sdsr_pkg::DOT && name_pos <= sdsr_pkg::EXT_POS) begin
                        name_pos = sdsr_pkg::EXT_POS;
                    end else begin
                        if (c >= 8'h61 && c <= 8'h7A) c = c - sdsr_pkg::SPACE;
                        name_pat[name_pos] = c;
                        name_pos = name_pos + 4'd1;
                    end
                end
            end
            sdsr_pkg::REQ_ENTRY: begin
                has = 1'b1;
                res.index = entry_cnt;
                hit = 1'b1;
                for (int k = 0; k < 8; k++)
                    if (it.head[8*k +: 8] != name_pat[k]) hit = 1'b0;
                for (int k = 0; k < 3; k++)
                    if (it.tail[8*k +: 8] != name_pat[8+k]) hit = 1'b0;
                if (search_over) begin
                    res.status = sdsr_pkg::ST_FINISHED;
                end else if (name_long) begin
                    search_over = 1'b1;
                    res.status = sdsr_pkg::ST_TOOLONG;
                end else if (entry_cnt >= entry_limit || it.head[7:0] == 8'h00) begin
                    search_over = 1'b1;
                    res.status = sdsr_pkg::ST_NOTFOUND;
                end else if ((it.etype & sdsr_pkg::SKIP_MASK) == 8'h00 && hit) begin
                    search_over = 1'b1;
                    res.status = sdsr_pkg::ST_FOUND;
                end else begin
                    entry_cnt = entry_cnt + 16'd1;
                    res.status = sdsr_pkg::ST_NONE;
                end
            end
            default: ;
        endcase
    endtask

    // Drive one beat, with an optional gap first; predict at acceptance
    task send_item(input t_req it, output bit has, output t_res res);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_req_type        <= it.req;
        i_name_char       <= it.ch;
        i_entry_name_head <= it.head;
        i_entry_name_tail <= it.tail;
        i_entry_type      <= it.etype;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        search_predict(it, has, res);
    endtask

    // Sender waits until every result is back and the pipe is empty
    task drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task write_max_entries(input logic [15:0] v);
        i_cfg_max_entries <= v;
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        entry_limit = v;
    endtask

    function t_req random_fields(input logic [1:0] req);
        t_req it;
        it.req   = req;
        it.ch    = 8'($urandom_range(0, 255));
        it.head  = {$urandom, $urandom};
        it.tail  = 24'($urandom);
        it.etype = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Mostly plausible file-name characters, some raw bytes and zeros
    function logic [7:0] random_name_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'(8'h61 + $urandom_range(0, 25));
            4:          return 8'(8'h41 + $urandom_range(0, 25));
            5:          return 8'(8'h30 + $urandom_range(0, 9));
            6:          return sdsr_pkg::DOT;
            7:          return 8'($urandom_range(1, 255));
            8:          return 8'h00;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Directory entry: exact pattern, near miss, end marker or random name
    function t_req random_entry();
        t_req it;
        int   k;
        it = random_fields(sdsr_pkg::REQ_ENTRY);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                for (int j = 0; j < 8; j++) it.head[8*j +: 8] = name_pat[j];
                for (int j = 0; j < 3; j++) it.tail[8*j +: 8] = name_pat[8+j];
                if ($urandom_range(0, 2) == 0) begin
                    k = $urandom_range(0, sdsr_pkg::NAME_LEN - 1);
                    if (k < 8) it.head[8*k +: 8] ^= 8'($urandom_range(1, 255));
                    else       it.tail[8*(k-8) +: 8] ^= 8'($urandom_range(1, 255));
                end
            end
            4:       it.head[7:0] = 8'h00;
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0) it.etype &= ~sdsr_pkg::SKIP_MASK;
        return it;
    endfunction

    function t_row row(input logic [1:0] req, input logic [7:0] ch, input logic [63:0] head,
                       input logic [23:0] tail, input logic [7:0] ty, input bit typed,
                       input logic [2:0] st, input logic [15:0] idx);
        row = '{'{req, ch, head, tail, ty}, typed, '{st, idx}};
    endfunction

    // One setting of the entry limit, then well-formed searches plus noise
    task run_searches(input logic [15:0] limit, input int n_items, input int idle);
        bit   has;
        t_res res;
        int   sent;
        int   nlen;
        drain_results();
        write_max_entries(limit);
        idle_pct = idle;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) != 0) begin
                send_item(random_fields(sdsr_pkg::REQ_BEGIN), has, res);
                sent++;
            end
            nlen = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
            repeat (nlen) begin
                t_req it;
                it = random_fields(sdsr_pkg::REQ_CHAR);
                it.ch = random_name_char();
                send_item(it, has, res);
                sent++;
                if ($urandom_range(0, 19) == 0) send_item(random_fields(REQ_RSVD), has, res);
            end
            repeat ($urandom_range(1, 10)) begin
                send_item(random_entry(), has, res);
                if (has) expected_results.push_back(res);
                sent++;
            end
        end
    endtask

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d entry_index %0d", o_status, o_entry_index);
                mismatch_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_status !== oldest_result.status) begin
                    $error("status: expected %0d, actual %0d", oldest_result.status, o_status);
                    mismatch_count++;
                end
                if (o_entry_index !== oldest_result.index) begin
                    $error("entry_index: expected %0d, actual %0d",
                           oldest_result.index, o_entry_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Result-side stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < idle_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Main sequence
    initial begin
        bit   has;
        t_res res;

        // Directed rows: match on the reset pattern of spaces, then finish; pattern "A" + "Z.",
        // extension byte 0xFF; then end marker, too-long name, finished search
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, 64'h2020202020202020, 24'h202020,
                               8'h00, 1, sdsr_pkg::ST_FOUND, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'hFF, 64'h2020202020202020, 24'h202020,
                               8'h00, 1, sdsr_pkg::ST_FINISHED, 16'd0));
        dir_rows.push_back(row(REQ_RSVD, 8'h41, '1, '1, '1,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_BEGIN, 8'h00, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, 8'h61, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, 8'h00, '1, '1, '1,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, sdsr_pkg::DOT, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, 8'h7A, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, sdsr_pkg::DOT, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, 8'hFF, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, 64'h2020202020202061, 24'hFF2E5A,
                               8'h00, 0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, 64'h2020202020202041, 24'hFF2E5A,
                               8'h10, 1, sdsr_pkg::ST_NONE, 16'd1));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, 64'h2020202020202041, 24'hFF2E5A,
                               8'h08, 1, sdsr_pkg::ST_NONE, 16'd2));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, 64'h2020202020202041, 24'hFF2E5A,
                               8'hE7, 1, sdsr_pkg::ST_FOUND, 16'd3));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, '1, '1, '1,
                               1, sdsr_pkg::ST_FINISHED, 16'd3));
        dir_rows.push_back(row(sdsr_pkg::REQ_BEGIN, 8'hFF, '1, '1, '1,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, 64'hFFFFFFFFFFFFFF00, '1, '1,
                               1, sdsr_pkg::ST_NOTFOUND, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_BEGIN, 8'h00, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, sdsr_pkg::DOT, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, 8'h78, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, 8'h79, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, 8'h71, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_CHAR, sdsr_pkg::DOT, '0, '0, '0,
                               0, sdsr_pkg::ST_NONE, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'h00, 64'h2020202020202020, 24'h515958,
                               8'h00, 1, sdsr_pkg::ST_TOOLONG, 16'd0));
        dir_rows.push_back(row(sdsr_pkg::REQ_ENTRY, 8'hFF, '1, '1, '1,
                               1, sdsr_pkg::ST_FINISHED, 16'd0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_search_state();
        entry_limit = sdsr_pkg::MAX_ENTRIES_RST;

        // Directed part at the reset limit
        idle_pct = 20;
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].req, has, res);
            if (has) expected_results.push_back(dir_rows[i].typed ? dir_rows[i].res : res);
        end

        // Random part across limit settings; last one without idling
        run_searches(16'd0, 200, 25);
        run_searches(16'd1, 250, 40);
        run_searches(16'd3, 250, 0);
        run_searches(16'hFFFF, 250, 25);
        run_searches(16'($urandom_range(2, 20)), 250, 15);
        run_searches(sdsr_pkg::MAX_ENTRIES_RST, 250, 0);

        drain_results();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: short_name_directory_search.f
sv/sdsr_pkg.sv
sv/sdsr_lane.sv
sv/sdsr_merge.sv
sv/short_name_directory_search.sv
tb/tb_top.sv
